FILE: sv/vrra_pkg.sv
// ------------------------------------------------------------------------
// vrra_pkg
// shared types and constants of the variable record ring allocator
// ------------------------------------------------------------------------
package vrra_pkg;

    localparam int MAX_WORDS_DEF  = 1024;
    localparam int WORD_BYTES_DEF = 4;

    localparam int OPCODE_W = 2;
    localparam int REQ_W    = 12;
    localparam int CAP_IN_W = 11;
    localparam int STATUS_W = 2;
    localparam int BYTES_W  = 12;
    localparam int COUNT_W  = 10;
    localparam int REC_W    = 11;
    localparam int CAP_RESET = 1024;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_DIV,
        S_PUSH_WR,
        S_PUSH_MARK,
        S_POP_LEN,
        S_POP_CHK,
        S_DONE
    } vrra_state_t;

endpackage

FILE: sv/variable_record_ring_allocator.sv
// steps: push divides and, unless full, writes its header and, on a wrap in a
// non-empty ring, a marker; pop or peek reads the length header, pop may then read the
// next one to skip a marker; empty pop or peek and unused opcode go straight to result;
// the single registered-read header memory port orders the steps, one beat in work at
// a time; a new beat is taken while the previous result waits in the output register
// reset: ring empty, positions zero, capacity min(1024, MAX_WORDS); no clearing pass
// ------------------------------------------------------------------------
// variable_record_ring_allocator
// header bookkeeping of a word-addressed ring of variable-size records
// ------------------------------------------------------------------------
module variable_record_ring_allocator #(
    parameter int MAX_WORDS  = vrra_pkg::MAX_WORDS_DEF,
    parameter int WORD_BYTES = vrra_pkg::WORD_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write channel: capacity_words
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vrra_pkg::CAP_IN_W-1:0]    cfg_data,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [vrra_pkg::S_TDATA_W-1:0]   s_tdata,   // request_bytes[11:0], zero pad
    input  logic [vrra_pkg::OPCODE_W-1:0]    s_tuser,   // opcode[1:0]
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vrra_pkg::M_TDATA_W-1:0]   m_tdata,   // payload_offset[11:0],
                                                        // payload_bytes[23:12],
                                                        // record_count[33:24], zero pad
    output logic [vrra_pkg::STATUS_W-1:0]    m_tuser    // status[1:0]
);
    import vrra_pkg::*;

    localparam int AW    = $clog2(MAX_WORDS);
    localparam int CAP_W = $clog2(MAX_WORDS + 1);
    localparam int CMP_W = (CAP_W > CAP_IN_W) ? CAP_W : CAP_IN_W;
    localparam int SW    = ((CAP_W > REC_W) ? CAP_W : REC_W) + 2;
    localparam int RESET_CAP = (CAP_RESET < MAX_WORDS) ? CAP_RESET : MAX_WORDS;
    // reciprocal for the round-up division by the word size
    localparam int SH       = 20;
    localparam int RECIP    = ((1 << SH) + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RECIP_W  = SH + 1;
    localparam int DIVIN_W  = REQ_W + 1;
    localparam int PROD_W   = DIVIN_W + RECIP_W;

    vrra_state_t          state_reg, state_next;
    logic [AW-1:0]        write_pos_reg, write_pos_next;
    logic [AW-1:0]        read_pos_reg, read_pos_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [OPCODE_W-1:0]  op_reg, op_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [REC_W-1:0]     rec_reg, rec_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 res_show_reg, res_show_next;
    logic [AW-1:0]        res_pos_reg, res_pos_next;
    logic [AW-1:0]        res_len_reg, res_len_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    // header memory, one port, registered read
    logic [AW-1:0]        hdr_mem [MAX_WORDS];
    logic [AW-1:0]        rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [AW-1:0]        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hdr_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= hdr_mem[mem_addr];
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        logic [CMP_W-1:0]    cap_in;
        logic [AW-1:0]       tail;
        logic [DIVIN_W-1:0]  div_in;
        logic [PROD_W-1:0]   prod;
        logic [SW-1:0]       head_s, rec_s, cap_s, read_s, pos_s;
        logic                wrap, full;
        logic [AW-1:0]       pos;
        logic [SW-1:0]       sum_s;
        logic [COUNT_W-1:0]  cnt_dec;
        logic [BYTES_W-1:0]  off_b, len_b;

        state_next      = state_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        op_next         = op_reg;
        req_next        = req_reg;
        rec_next        = rec_reg;
        tail_next       = tail_reg;
        res_status_next = res_status_reg;
        res_show_next   = res_show_reg;
        res_pos_next    = res_pos_reg;
        res_len_next    = res_len_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_addr        = tail_reg;
        mem_wdata       = '0;

        cap_in  = CMP_W'(cfg_data);
        tail    = (CAP_W'(read_pos_reg) < cap_reg) ? read_pos_reg : '0;
        div_in  = DIVIN_W'(req_reg) + DIVIN_W'(WORD_BYTES - 1);
        prod    = PROD_W'(div_in) * PROD_W'(RECIP);
        head_s  = SW'(write_pos_reg);
        rec_s   = SW'(rec_reg);
        cap_s   = SW'(cap_reg);
        read_s  = SW'(read_pos_reg);
        wrap    = (head_s + rec_s + SW'(1)) >= cap_s;
        pos     = wrap ? '0 : write_pos_reg;
        pos_s   = SW'(pos);
        sum_s   = SW'(tail_reg) + SW'(rdata_reg);
        cnt_dec = count_reg - COUNT_W'(1);
        off_b   = 12'((12'(res_pos_reg) + 12'd1) * 12'(WORD_BYTES));
        len_b   = 12'((12'(res_len_reg) - 12'd1) * 12'(WORD_BYTES));

        full = 1'b0;
        if ((rec_s + SW'(1)) >= cap_s || count_reg >= COUNT_MAX)
        begin
            full = 1'b1;
        end
        else if (count_reg != '0)
        begin
            if (wrap && head_s <= read_s)
            begin
                full = 1'b1;
            end
            else if (pos_s <= read_s && (pos_s + rec_s) > read_s)
            begin
                full = 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cap_in < CMP_W'(2))
                    begin
                        cap_next = CAP_W'(2);
                    end
                    else if (cap_in > CMP_W'(MAX_WORDS))
                    begin
                        cap_next = CAP_W'(MAX_WORDS);
                    end
                    else
                    begin
                        cap_next = CAP_W'(cap_in);
                    end
                    write_pos_next = '0;
                    read_pos_next  = '0;
                    count_next     = '0;
                end
                else if (s_tvalid)
                begin
                    op_next       = s_tuser;
                    req_next      = s_tdata[REQ_W-1:0];
                    res_status_next = STAT_OK;
                    res_show_next = 1'b0;
                    case (s_tuser)
                        OP_PUSH:
                        begin
                            state_next = S_PUSH_DIV;
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                mem_addr   = tail;
                                tail_next  = tail;
                                state_next = S_POP_LEN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUSH_DIV:
            begin
                rec_next   = REC_W'(prod[SH+REC_W-1:SH]) + REC_W'(1);
                state_next = S_PUSH_WR;
            end

            S_PUSH_WR:
            begin
                if (full)
                begin
                    res_status_next = STAT_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_addr       = pos;
                    mem_wdata      = AW'(rec_reg);
                    write_pos_next = AW'(pos_s + rec_s);
                    count_next     = count_reg + COUNT_W'(1);
                    res_show_next  = 1'b1;
                    res_pos_next   = pos;
                    res_len_next   = AW'(rec_reg);
                    if (count_reg == '0)
                    begin
                        read_pos_next = pos;
                        state_next    = S_DONE;
                    end
                    else if (wrap)
                    begin
                        tail_next  = write_pos_reg;
                        state_next = S_PUSH_MARK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_PUSH_MARK:
            begin
                // wrap marker at the old write position
                mem_we     = 1'b1;
                mem_addr   = tail_reg;
                mem_wdata  = '0;
                state_next = S_DONE;
            end

            S_POP_LEN:
            begin
                res_show_next = 1'b1;
                res_pos_next  = tail_reg;
                res_len_next  = rdata_reg;
                if (op_reg == OP_POP)
                begin
                    count_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        read_pos_next = write_pos_reg;
                        state_next    = S_DONE;
                    end
                    else if (sum_s >= cap_s)
                    begin
                        read_pos_next = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        mem_addr   = AW'(sum_s);
                        tail_next  = AW'(sum_s);
                        state_next = S_POP_CHK;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_POP_CHK:
            begin
                // skip a wrap marker
                read_pos_next = (rdata_reg == '0) ? '0 : tail_reg;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = '0;
                    m_tdata_next[BYTES_W-1:0] = res_show_reg ? off_b : '0;
                    m_tdata_next[2*BYTES_W-1:BYTES_W] =
                        (res_show_reg && res_len_reg != '0) ? len_b : '0;
                    m_tdata_next[2*BYTES_W+COUNT_W-1:2*BYTES_W] = count_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(RESET_CAP);
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        rec_reg        <= rec_next;
        tail_reg       <= tail_next;
        res_status_reg <= res_status_next;
        res_show_reg   <= res_show_next;
        res_pos_reg    <= res_pos_next;
        res_len_reg    <= res_len_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // positions stay inside the ring
    a_write_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_W'(write_pos_reg) < cap_reg)
        else $error("write position outside ring");

    a_read_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_W'(read_pos_reg) < cap_reg)
        else $error("read position outside ring");

    // header memory is written only by a push
    a_write_only_push: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_PUSH_WR || state_reg == S_PUSH_MARK))
        else $error("header write outside push");

    // an accepted beat starts work and leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg != S_IDLE)
        else $error("accepted beat not processed");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH_WR && count_reg == COUNT_MAX) |=> count_reg == COUNT_MAX)
        else $error("record count passed limit");

endmodule
